### hdl/pvo_pkg.sv
// shared types, constants and an arithmetic helper for the pair virial accumulator
`default_nettype none
package pvo_pkg;

    localparam int VIR_WORDS     = 9;
    localparam int DEF_MAX_ATOMS = 1024;
    localparam int IDX_W         = 11;
    localparam int COMP_W        = 32;
    localparam int ACC_W         = 64;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ACCUM = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic mul_en;
        logic glob_upd;
        logic glob_clr;
    } lane_ctrl_t;

    typedef struct packed {
        logic fire;
        logic is_read;
        logic atom_hit;
    } merge_ctrl_t;

    // a - b clamped to the signed accumulator range
    function automatic acc_t sat_sub(input acc_t a, input acc_t b);
        logic signed [ACC_W:0] diff;
        acc_t                  res;
        diff = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (diff[ACC_W] != diff[ACC_W-1])
        begin
            res = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            res = diff[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hdl/pvo_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module pvo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hdl/pvo_lane.sv
// one tensor component: product, global word and per-atom update
`default_nettype none
module pvo_lane
    import pvo_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lane_ctrl_t ctrl,
    input  wire comp_t      d,
    input  wire comp_t      r,
    input  wire acc_t       atom_rd,
    input  wire logic       atom_vld,
    output acc_t            glob_next,
    output acc_t            atom_cur,
    output acc_t            atom_new
);

    acc_t prod_reg;
    acc_t prod_next;
    acc_t glob_reg;

    assign prod_next = d * r;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // an atom whose valid bit is clear starts from zero
    assign atom_cur = atom_vld ? atom_rd : '0;
    assign atom_new = sat_sub(atom_cur, prod_reg);

    always_comb
    begin
        if (ctrl.glob_clr)
        begin
            glob_next = '0;
        end
        else if (ctrl.glob_upd)
        begin
            glob_next = sat_sub(glob_reg, prod_reg);
        end
        else
        begin
            glob_next = glob_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_reg <= '0;
        end
        else
        begin
            glob_reg <= glob_next;
        end
    end

endmodule
`default_nettype wire

### hdl/pvo_merge.sv
// result stage: picks global or atom words from the lanes and registers them
`default_nettype none
module pvo_merge
    import pvo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire merge_ctrl_t ctrl,
    input  wire acc_t        glob_next [VIR_WORDS],
    input  wire acc_t        atom_cur  [VIR_WORDS],
    output logic             done,
    output acc_t             vir       [VIR_WORDS]
);

    logic done_reg;
    acc_t vir_reg [VIR_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            for (int k = 0; k < VIR_WORDS; k++)
            begin
                if (ctrl.is_read)
                begin
                    vir_reg[k] <= ctrl.atom_hit ? atom_cur[k] : '0;
                end
                else
                begin
                    vir_reg[k] <= glob_next[k];
                end
            end
        end
    end

    assign done = done_reg;
    assign vir  = vir_reg;

endmodule
`default_nettype wire

### hdl/pair_virial_outer_product_accumulate.sv
// top level: pair virial outer product accumulator with per-atom store
//
//  channel   signals                                   handshake
//  command   start, operation, neighbor_index,         taken when start && !busy
//            deriv_x/y/z, disp_x/y/z
//  result    done, vir_xx .. vir_zz                    one cycle, done high
//
// an accumulate, read or unused code passes through accept, ram read plus
// product and update; the result word shows in the cycle after the update,
// while a new command may already be taken. nine lanes each own one 32x32
// multiplier and two 64-bit saturating subtracts. a clear also sweeps the
// valid-bit ram, one atom a cycle, with busy high; the same sweep runs
// right after reset. the receiver cannot stall.
`default_nettype none
module pair_virial_outer_product_accumulate
    import pvo_pkg::*;
#(
    parameter int MAX_ATOMS = DEF_MAX_ATOMS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic        [1:0]       operation,
    input  wire logic signed [IDX_W-1:0] neighbor_index,
    input  wire comp_t                   deriv_x,
    input  wire comp_t                   deriv_y,
    input  wire comp_t                   deriv_z,
    input  wire comp_t                   disp_x,
    input  wire comp_t                   disp_y,
    input  wire comp_t                   disp_z,
    output logic                         done,
    output acc_t                         vir_xx,
    output acc_t                         vir_xy,
    output acc_t                         vir_xz,
    output acc_t                         vir_yx,
    output acc_t                         vir_yy,
    output acc_t                         vir_yz,
    output acc_t                         vir_zx,
    output acc_t                         vir_zy,
    output acc_t                         vir_zz
);

    localparam int ADDR_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ATOM = ADDR_W'(MAX_ATOMS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CALC  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       cnt_reg, cnt_next;
    logic [1:0]              op_reg;
    logic signed [IDX_W-1:0] idx_reg;
    comp_t                   d_reg [3];
    comp_t                   r_reg [3];

    logic [ADDR_W-1:0] idx_addr;
    logic              idx_neg;
    logic              in_range;
    logic              acc_hit;
    logic              atom_wr;
    logic              vld_rd;
    logic              vld_we;
    logic [ADDR_W-1:0] vld_waddr;
    logic              vld_wdata;

    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;
    acc_t        atom_rd   [VIR_WORDS];
    acc_t        atom_cur  [VIR_WORDS];
    acc_t        atom_new  [VIR_WORDS];
    acc_t        glob_next [VIR_WORDS];
    acc_t        vir       [VIR_WORDS];

    assign busy = (state_reg != S_IDLE);

    // command capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= operation;
            idx_reg  <= neighbor_index;
            d_reg[0] <= deriv_x;
            d_reg[1] <= deriv_y;
            d_reg[2] <= deriv_z;
            r_reg[0] <= disp_x;
            r_reg[1] <= disp_y;
            r_reg[2] <= disp_z;
        end
    end

    assign idx_addr = ADDR_W'(idx_reg[IDX_W-2:0]);
    assign idx_neg  = idx_reg[IDX_W-1];
    assign in_range = !idx_neg && (32'(idx_reg[IDX_W-2:0]) < 32'(MAX_ATOMS));
    assign acc_hit  = (op_reg == OP_ACCUM) && !idx_neg;
    assign atom_wr  = (state_reg == S_CALC) && acc_hit && in_range;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ATOM)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = (op_reg == OP_CLEAR) ? S_CLEAR : S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // valid bits: swept to zero on clear, set on first accumulate
    assign vld_we    = (state_reg == S_CLEAR) || atom_wr;
    assign vld_waddr = (state_reg == S_CLEAR) ? cnt_reg : idx_addr;
    assign vld_wdata = (state_reg != S_CLEAR);

    pvo_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ATOMS),
        .ADDR_W(ADDR_W)
    ) u_vld_ram (
        .clk  (clk),
        .we   (vld_we),
        .waddr(vld_waddr),
        .wdata(vld_wdata),
        .raddr(idx_addr),
        .rdata(vld_rd)
    );

    assign lane_ctrl.mul_en   = (state_reg == S_READ);
    assign lane_ctrl.glob_upd = (state_reg == S_CALC) && acc_hit;
    assign lane_ctrl.glob_clr = (state_reg == S_CALC) && (op_reg == OP_CLEAR);

    for (genvar k = 0; k < VIR_WORDS; k++)
    begin : g_lane
        pvo_ram #(
            .WIDTH (ACC_W),
            .DEPTH (MAX_ATOMS),
            .ADDR_W(ADDR_W)
        ) u_atom_ram (
            .clk  (clk),
            .we   (atom_wr),
            .waddr(idx_addr),
            .wdata(atom_new[k]),
            .raddr(idx_addr),
            .rdata(atom_rd[k])
        );

        // lane k is row k/3 (derivative axis), column k%3 (displacement axis)
        pvo_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .d        (d_reg[k / 3]),
            .r        (r_reg[k % 3]),
            .atom_rd  (atom_rd[k]),
            .atom_vld (vld_rd),
            .glob_next(glob_next[k]),
            .atom_cur (atom_cur[k]),
            .atom_new (atom_new[k])
        );
    end

    assign merge_ctrl.fire     = (state_reg == S_CALC);
    assign merge_ctrl.is_read  = (op_reg == OP_READ);
    assign merge_ctrl.atom_hit = in_range && vld_rd;

    pvo_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (merge_ctrl),
        .glob_next(glob_next),
        .atom_cur (atom_cur),
        .done     (done),
        .vir      (vir)
    );

    assign vir_xx = vir[0];
    assign vir_xy = vir[1];
    assign vir_xz = vir[2];
    assign vir_yx = vir[3];
    assign vir_yy = vir[4];
    assign vir_yz = vir[5];
    assign vir_zx = vir[6];
    assign vir_zy = vir[7];
    assign vir_zz = vir[8];

`ifndef SYNTH
    // a result word follows only an update cycle
    a_done_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_CALC))
        else $error("result word without update cycle");

    // no command is taken while the valid bits are being swept
    a_busy_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("ready during valid-bit sweep");

    // a clear returns an all-zero tensor
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (op_reg == OP_CLEAR)) |-> (vir_xx == '0 && vir_yy == '0 && vir_zz == '0))
        else $error("clear returned nonzero words");

    // the per-atom store is only written in the update cycle
    a_atom_wr_calc: assert property (@(posedge clk) disable iff (!rst_n)
        atom_wr |-> (state_reg == S_CALC) && !vld_we == 1'b0)
        else $error("atom write outside update cycle");
`endif

endmodule
`default_nettype wire

### tb/pvo_checker.sv
// checker for the pair virial accumulator: tracks the virial state, predicts and compares results
module pvo_checker
    import pvo_pkg::*;
#(
    parameter int MAX_ATOMS = DEF_MAX_ATOMS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic        [1:0]       operation,
    input  wire logic signed [IDX_W-1:0] neighbor_index,
    input  wire comp_t                   deriv_x,
    input  wire comp_t                   deriv_y,
    input  wire comp_t                   deriv_z,
    input  wire comp_t                   disp_x,
    input  wire comp_t                   disp_y,
    input  wire comp_t                   disp_z,
    input  wire logic                    done,
    input  wire acc_t                    vir_xx,
    input  wire acc_t                    vir_xy,
    input  wire acc_t                    vir_xz,
    input  wire acc_t                    vir_yx,
    input  wire acc_t                    vir_yy,
    input  wire acc_t                    vir_yz,
    input  wire acc_t                    vir_zx,
    input  wire acc_t                    vir_zy,
    input  wire acc_t                    vir_zz,
    output int                           errors,
    output int                           pending,
    output int                           compared
);
    timeunit 1ns;
    timeprecision 1ps;

    // nine Q32.32 words, word a*3+b is row a (derivative) and column b (displacement)
    typedef logic [VIR_WORDS-1:0][ACC_W-1:0] tensor_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    acc_t    frame_virial [VIR_WORDS];
    acc_t    atom_tensor  [MAX_ATOMS][VIR_WORDS];
    bit      atom_live    [MAX_ATOMS];
    tensor_t expected_virials [$];

    function automatic acc_t clamped_sub(input acc_t acc, input acc_t prod);
        if (prod > 0 && acc < ACC_MIN + prod)
            return ACC_MIN;
        if (prod < 0 && acc > ACC_MAX + prod)
            return ACC_MAX;
        return acc - prod;
    endfunction

    function automatic string lane_label(input int w);
        string axes;
        axes = "xyz";
        return {"vir_", axes.substr(w / 3, w / 3), axes.substr(w % 3, w % 3)};
    endfunction

    // updates the tracked virials for one command word and returns the result it gives
    function automatic tensor_t predict_virial(input logic [1:0] op,
                                               input logic signed [IDX_W-1:0] idx,
                                               input comp_t d [3],
                                               input comp_t r [3]);
        tensor_t word;
        acc_t    prod;
        int      atom;
        bit      in_range;
        word = '0;
        atom = idx;
        in_range = (atom >= 0) && (atom < MAX_ATOMS);
        case (op)
            OP_CLEAR:
            begin
                frame_virial = '{default: '0};
                atom_live = '{default: 1'b0};
            end
            OP_READ:
            begin
                if (in_range && atom_live[atom])
                    for (int w = 0; w < VIR_WORDS; w++)
                        word[w] = atom_tensor[atom][w];
                return word;
            end
            OP_ACCUM:
            begin
                if (atom >= 0)
                begin
                    // first touch since the last clear starts the atom from zero
                    if (in_range && !atom_live[atom])
                    begin
                        atom_tensor[atom] = '{default: '0};
                        atom_live[atom] = 1'b1;
                    end
                    for (int a = 0; a < 3; a++)
                        for (int b = 0; b < 3; b++)
                        begin
                            prod = acc_t'(d[a]) * acc_t'(r[b]);
                            frame_virial[a*3+b] = clamped_sub(frame_virial[a*3+b], prod);
                            if (in_range)
                                atom_tensor[atom][a*3+b] = clamped_sub(atom_tensor[atom][a*3+b], prod);
                        end
                end
            end
            default: ;
        endcase
        for (int w = 0; w < VIR_WORDS; w++)
            word[w] = frame_virial[w];
        return word;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tensor_t seen;
        tensor_t want;
        comp_t   d [3];
        comp_t   r [3];
        if (!rst_n)
        begin
            frame_virial = '{default: '0};
            atom_live = '{default: 1'b0};
            expected_virials.delete();
            pending = 0;
        end
        else
        begin
            // a result word always belongs to an earlier command, so compare before taking one
            if (done)
            begin
                seen = {vir_zz, vir_zy, vir_zx, vir_yz, vir_yy, vir_yx, vir_xz, vir_xy, vir_xx};
                if (expected_virials.size() == 0)
                begin
                    report_mismatch("result word with nothing outstanding");
                end
                else
                begin
                    want = expected_virials.pop_front();
                    compared++;
                    for (int w = 0; w < VIR_WORDS; w++)
                        if (seen[w] !== want[w])
                            report_mismatch($sformatf("%s got %h want %h",
                                                      lane_label(w), seen[w], want[w]));
                end
            end
            if (start && !busy)
            begin
                d = '{deriv_x, deriv_y, deriv_z};
                r = '{disp_x, disp_y, disp_z};
                expected_virials.insert(expected_virials.size(),
                                        predict_virial(operation, neighbor_index, d, r));
            end
            pending = expected_virials.size();
        end
    end

endmodule

### tb/testbench.sv
// top of the pair virial accumulator bench: clock, reset, command stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pvo_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1250;
    localparam int         HOT_COUNT    = 8;
    localparam int         TAIL_CYCLES  = 8;
    localparam int         SMALL_SPAN   = 1 << 20;
    localparam comp_t      Q_MAX        = 32'sh7fff_ffff;
    localparam comp_t      Q_MIN        = 32'sh8000_0000;
    localparam comp_t      Q_ONE        = 32'sh0001_0000;
    localparam comp_t      Q_ZERO       = 32'sh0000_0000;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic        [1:0]       operation;
    logic signed [IDX_W-1:0] neighbor_index;
    comp_t                   deriv_x, deriv_y, deriv_z;
    comp_t                   disp_x, disp_y, disp_z;
    logic                    done;
    acc_t                    vir_xx, vir_xy, vir_xz;
    acc_t                    vir_yx, vir_yy, vir_yz;
    acc_t                    vir_zx, vir_zy, vir_zz;
    int                      errors;
    int                      pending;
    int                      compared;

    int burst_left;
    int n_clear, n_accum, n_skip, n_read, n_unused;
    bit touched [DEF_MAX_ATOMS];

    pair_virial_outer_product_accumulate #(
        .MAX_ATOMS(DEF_MAX_ATOMS)
    ) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .neighbor_index(neighbor_index),
        .deriv_x(deriv_x), .deriv_y(deriv_y), .deriv_z(deriv_z),
        .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
        .done(done),
        .vir_xx(vir_xx), .vir_xy(vir_xy), .vir_xz(vir_xz),
        .vir_yx(vir_yx), .vir_yy(vir_yy), .vir_yz(vir_yz),
        .vir_zx(vir_zx), .vir_zy(vir_zy), .vir_zz(vir_zz)
    );

    pvo_checker #(
        .MAX_ATOMS(DEF_MAX_ATOMS)
    ) u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .neighbor_index(neighbor_index),
        .deriv_x(deriv_x), .deriv_y(deriv_y), .deriv_z(deriv_z),
        .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
        .done(done),
        .vir_xx(vir_xx), .vir_xy(vir_xy), .vir_xz(vir_xz),
        .vir_yx(vir_yx), .vir_yy(vir_yy), .vir_yz(vir_yz),
        .vir_zx(vir_zx), .vir_zy(vir_zy), .vir_zz(vir_zz),
        .errors(errors), .pending(pending), .compared(compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // covers the post-reset sweep, a few dozen clear sweeps and every gap many times over
    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic comp_t rand_comp(input bit wide);
        if (wide)
            return comp_t'($urandom);
        return comp_t'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
    endfunction

    // drives one command word and holds it until taken; bursts end in a random gap
    task automatic issue(input logic [1:0] op, input int idx,
                         input comp_t dx, input comp_t dy, input comp_t dz,
                         input comp_t rx, input comp_t ry, input comp_t rz);
        int gap;
        @(negedge clk);
        start = 1'b1;
        operation = op;
        neighbor_index = IDX_W'(idx);
        deriv_x = dx;
        deriv_y = dy;
        deriv_z = dz;
        disp_x = rx;
        disp_y = ry;
        disp_z = rz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (op)
            OP_CLEAR: n_clear++;
            OP_READ:  n_read++;
            OP_ACCUM:
            begin
                n_accum++;
                if (idx < 0)
                    n_skip++;
                else
                    touched[idx] = 1'b1;
            end
            default:  n_unused++;
        endcase
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int  hot_atoms [HOT_COUNT];
        int  pick;
        int  sel;
        int  hot;
        int  target;
        bit  wide;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_CLEAR;
        neighbor_index = '0;
        deriv_x = '0;
        deriv_y = '0;
        deriv_z = '0;
        disp_x = '0;
        disp_y = '0;
        disp_z = '0;
        burst_left = 1;
        hot_atoms[0] = 0;
        hot_atoms[1] = DEF_MAX_ATOMS - 1;
        for (int i = 2; i < HOT_COUNT; i++)
            hot_atoms[i] = $urandom_range(0, DEF_MAX_ATOMS - 1);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every operation, the field extremes, both saturation rails
        issue(OP_CLEAR, 0, rand_comp(1), rand_comp(1), rand_comp(1),
              rand_comp(1), rand_comp(1), rand_comp(1));
        issue(OP_READ, -1, rand_comp(1), rand_comp(1), rand_comp(1),
              rand_comp(1), rand_comp(1), rand_comp(1));
        issue(OP_ACCUM, 0, Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE / 2, -Q_ONE, 4 * Q_ONE);
        issue(OP_READ, 0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        issue(OP_ACCUM, DEF_MAX_ATOMS - 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        // largest positive product twice walks the sums into the negative rail
        repeat (2)
            issue(OP_ACCUM, DEF_MAX_ATOMS - 1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        repeat (5)
            issue(OP_ACCUM, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        issue(OP_ACCUM, -1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        issue(OP_UNUSED, DEF_MAX_ATOMS - 1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        issue(OP_READ, 0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        issue(OP_READ, DEF_MAX_ATOMS - 1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        issue(OP_ACCUM, 512, Q_MAX, Q_MIN, Q_ZERO, Q_MIN, Q_MAX, Q_ONE);
        issue(OP_READ, 512, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        issue(OP_CLEAR, DEF_MAX_ATOMS - 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        // cleared atom reads zero, then restarts from zero
        issue(OP_READ, 0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        issue(OP_ACCUM, 0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        issue(OP_ACCUM, 0, -Q_ONE, Q_ONE, Q_ONE / 4, 3 * Q_ONE, -Q_ONE / 8, Q_ONE);
        issue(OP_READ, 0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        drain();

        // random: mostly pairs onto a few hot atoms so reads and back-to-back updates collide
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            wide = ($urandom_range(0, 3) == 0);
            hot = hot_atoms[$urandom_range(0, HOT_COUNT - 1)];
            if (pick < 3)
            begin
                issue(OP_CLEAR, $urandom_range(0, DEF_MAX_ATOMS - 1),
                      rand_comp(1), rand_comp(1), rand_comp(1),
                      rand_comp(1), rand_comp(1), rand_comp(1));
            end
            else if (pick < 5)
            begin
                issue(OP_UNUSED, $urandom_range(0, DEF_MAX_ATOMS - 1),
                      rand_comp(1), rand_comp(1), rand_comp(1),
                      rand_comp(1), rand_comp(1), rand_comp(1));
            end
            else if (pick < 25)
            begin
                // reads go only to atoms that have held data, or to index -1
                target = (touched[hot] && $urandom_range(0, 9) != 0) ? hot : -1;
                issue(OP_READ, target, rand_comp(1), rand_comp(1), rand_comp(1),
                      rand_comp(1), rand_comp(1), rand_comp(1));
            end
            else
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    target = -1;
                else if (sel < 5)
                    target = $urandom_range(0, DEF_MAX_ATOMS - 1);
                else
                    target = hot;
                issue(OP_ACCUM, target, rand_comp(wide), rand_comp(wide), rand_comp(wide),
                      rand_comp(wide), rand_comp(wide), rand_comp(wide));
            end
            if ($urandom_range(0, 99) == 0)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("covered %0d clears, %0d pair words (%0d empty slots), %0d reads, %0d unused codes",
                 n_clear, n_accum, n_skip, n_read, n_unused);
        $display("%0d result words compared, %0d mismatches", compared, errors);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### filelist.f
hdl/pvo_pkg.sv
hdl/pvo_ram.sv
hdl/pvo_lane.sv
hdl/pvo_merge.sv
hdl/pair_virial_outer_product_accumulate.sv
tb/pvo_checker.sv
tb/testbench.sv
